@@ hdl/l4_pseudo_header_checksum_unit_macros.svh @@
// Assertion macros for the pseudo-header checksum unit.
// Included by the top level. Depends on nothing else.
`ifndef L4_PSEUDO_HEADER_CHECKSUM_UNIT_MACROS_SVH
`define L4_PSEUDO_HEADER_CHECKSUM_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define L4PC_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define L4PC_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ hdl/l4pc_pkg.sv @@
// Package for the pseudo-header checksum unit: field widths, item kind codes
// and the word mask. Depends on nothing.
package l4pc_pkg;

  localparam int WordW  = 16;
  localparam int ByteW  = 8;
  localparam int ProtoW = 8;

  localparam logic [WordW-1:0] WORD_MASK = 16'hFFFF;

  localparam logic KIND_ADDR = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

endpackage

@@ hdl/l4_pseudo_header_checksum_unit.sv @@
// Top level of the pseudo-header checksum unit: input word register, running
// sum and packet state, and the result register.
// Depends on l4pc_pkg and l4_pseudo_header_checksum_unit_macros.svh.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, value, protocol, last
//   out      output     out_valid / out_ready  checksum, too_long
//   cfg      input      cfg_write              cfg_data
//
// One word a cycle is sustained while no last word waits on a stalled
// result; a word is held in the input word register and then added into the
// packet state, and a last word has its result registered as it is added.
// The five-operand add and its two end-around folds set the cycle time.
// Reset clears the packet state and sets pseudo-header mode on.
// A stalled result blocks only a following last word; other words keep
// flowing into the running sum.
`include "l4_pseudo_header_checksum_unit_macros.svh"

module l4_pseudo_header_checksum_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [l4pc_pkg::WordW-1:0]     value,
  input  logic [l4pc_pkg::ProtoW-1:0]    protocol,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [l4pc_pkg::WordW-1:0]     checksum,
  output logic                           too_long,
  input  logic                           cfg_write,
  input  logic                           cfg_data
);

  localparam int W = l4pc_pkg::WordW;

  logic                         pseudo_header_enable;

  logic                         s1_valid;
  logic                         s1_kind;
  logic [W-1:0]                 s1_value;
  logic [l4pc_pkg::ProtoW-1:0]  s1_protocol;
  logic                         s1_last;

  logic [W-1:0]                 running_sum;
  logic [W-1:0]                 byte_count;
  logic [l4pc_pkg::ByteW-1:0]   held_high_byte;
  logic                         byte_pending;
  logic                         count_overflow;

  logic                         slot_free;
  logic                         advance;
  logic [l4pc_pkg::ByteW-1:0]   new_byte;
  logic                         is_byte;
  logic                         at_max;
  logic [W-1:0]                 byte_count_next;
  logic                         count_overflow_next;
  logic [l4pc_pkg::ByteW-1:0]   held_high_byte_next;
  logic                         byte_pending_next;
  logic [W-1:0]                 item_word;
  logic [W-1:0]                 pad_word;
  logic [W-1:0]                 len_word;
  logic [W-1:0]                 proto_word;
  logic [W+2:0]                 total;
  logic [W:0]                   fold1;
  logic [W-1:0]                 running_sum_next;

  assign slot_free = !out_valid || out_ready;
  assign advance   = s1_valid && (!s1_last || slot_free);
  assign in_ready  = !s1_valid || advance;

  assign new_byte = s1_value[l4pc_pkg::ByteW-1:0];
  assign is_byte  = (s1_kind == l4pc_pkg::KIND_BYTE);
  assign at_max   = (byte_count == l4pc_pkg::WORD_MASK);

  always_comb begin
    byte_count_next     = byte_count;
    count_overflow_next = count_overflow;
    held_high_byte_next = held_high_byte;
    byte_pending_next   = byte_pending;
    item_word           = '0;
    if (!is_byte) begin
      item_word = s1_value;
    end else begin
      if (at_max) begin
        count_overflow_next = 1'b1;
      end else begin
        byte_count_next = byte_count + W'(1);
      end
      if (byte_pending) begin
        item_word           = {held_high_byte, new_byte};
        held_high_byte_next = '0;
        byte_pending_next   = 1'b0;
      end else begin
        held_high_byte_next = new_byte;
        byte_pending_next   = 1'b1;
      end
    end
    pad_word   = '0;
    len_word   = '0;
    proto_word = '0;
    if (s1_last) begin
      if (byte_pending_next) begin
        pad_word = {held_high_byte_next, {l4pc_pkg::ByteW{1'b0}}};
      end
      if (pseudo_header_enable) begin
        len_word   = byte_count_next;
        proto_word = {{(W-l4pc_pkg::ProtoW){1'b0}}, s1_protocol};
      end
    end
    total = {3'b000, running_sum} + {3'b000, item_word} + {3'b000, pad_word}
          + {3'b000, len_word} + {3'b000, proto_word};
    fold1 = {1'b0, total[W-1:0]} + {{(W-2){1'b0}}, total[W+2:W]};
    running_sum_next = fold1[W-1:0] + {{(W-1){1'b0}}, fold1[W]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pseudo_header_enable <= 1'b1;
      s1_valid             <= 1'b0;
      out_valid            <= 1'b0;
      running_sum          <= '0;
      byte_count           <= '0;
      held_high_byte       <= '0;
      byte_pending         <= 1'b0;
      count_overflow       <= 1'b0;
    end else begin
      if (cfg_write) begin
        pseudo_header_enable <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        if (s1_last) begin
          running_sum    <= '0;
          byte_count     <= '0;
          held_high_byte <= '0;
          byte_pending   <= 1'b0;
          count_overflow <= 1'b0;
          out_valid      <= 1'b1;
          checksum       <= ~running_sum_next;
          too_long       <= count_overflow_next;
        end else begin
          running_sum    <= running_sum_next;
          byte_count     <= byte_count_next;
          held_high_byte <= held_high_byte_next;
          byte_pending   <= byte_pending_next;
          count_overflow <= count_overflow_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind     <= kind;
      s1_value    <= value;
      s1_protocol <= protocol;
      s1_last     <= last;
    end
  end

  `L4PC_ASSERT_NEXT(a_last_gives_result, clk, rst, advance && s1_last, out_valid,
                    "last word did not produce a result")
  `L4PC_ASSERT_NEXT(a_last_clears_state, clk, rst, advance && s1_last,
                    running_sum == '0 && byte_count == '0 && !byte_pending && !count_overflow,
                    "packet state not cleared after last word")
  `L4PC_ASSERT_NOW(a_held_clear_when_idle, clk, rst, !byte_pending, held_high_byte == '0,
                   "held byte nonzero with no byte pending")
  `L4PC_ASSERT_NOW(a_overflow_saturates, clk, rst, count_overflow,
                   byte_count == l4pc_pkg::WORD_MASK,
                   "overflow flagged without saturated count")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for l4_pseudo_header_checksum_unit: directed and random packets
// against a built-in checksum predictor, with random idling on both channels.
// Depends on l4pc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [l4pc_pkg::WordW-1:0] checksum;
    logic                       too_long;
  } csum_result_t;

  class checksum_scoreboard;
    csum_result_t               expected_sums[$];
    bit                         hdr_mode;
    logic [l4pc_pkg::WordW-1:0] sum;
    logic [l4pc_pkg::WordW-1:0] byte_cnt;
    logic [l4pc_pkg::ByteW-1:0] high_byte;
    bit                         byte_held;
    bit                         cnt_overflow;
    int                         errors;
    int                         results_seen;

    function new();
      hdr_mode = 1'b1;
      errors = 0;
      results_seen = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      sum = '0;
      byte_cnt = '0;
      high_byte = '0;
      byte_held = 1'b0;
      cnt_overflow = 1'b0;
    endfunction

    function logic [l4pc_pkg::WordW-1:0] ones_add(logic [l4pc_pkg::WordW-1:0] a,
                                                  logic [l4pc_pkg::WordW-1:0] b);
      logic [l4pc_pkg::WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[l4pc_pkg::WordW-1:0] + {{(l4pc_pkg::WordW-1){1'b0}}, s[l4pc_pkg::WordW]};
    endfunction

    function void set_mode(bit m);
      hdr_mode = m;
    endfunction

    function void absorb_word(logic k, logic [l4pc_pkg::WordW-1:0] v,
                              logic [l4pc_pkg::ProtoW-1:0] p, logic l);
      csum_result_t r;
      if (k == l4pc_pkg::KIND_ADDR) begin
        sum = ones_add(sum, v);
      end else begin
        if (byte_cnt == l4pc_pkg::WORD_MASK) begin
          cnt_overflow = 1'b1;
        end else begin
          byte_cnt = byte_cnt + {{(l4pc_pkg::WordW-1){1'b0}}, 1'b1};
        end
        if (byte_held) begin
          sum = ones_add(sum, {high_byte, v[l4pc_pkg::ByteW-1:0]});
          byte_held = 1'b0;
          high_byte = '0;
        end else begin
          high_byte = v[l4pc_pkg::ByteW-1:0];
          byte_held = 1'b1;
        end
      end
      if (l) begin
        if (byte_held) begin
          sum = ones_add(sum, {high_byte, 8'h00});
        end
        if (hdr_mode) begin
          sum = ones_add(sum, byte_cnt);
          sum = ones_add(sum, {8'h00, p});
        end
        r.checksum = ~sum;
        r.too_long = cnt_overflow;
        expected_sums.push_back(r);
        clear_packet();
      end
    endfunction

    task report_mismatch(string msg);
      if (errors < 100) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_result(logic [l4pc_pkg::WordW-1:0] cs, logic tl);
      csum_result_t r;
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: checksum %h too_long %b",
                                  results_seen, cs, tl));
      end else begin
        r = expected_sums.pop_front();
        if (cs !== r.checksum) begin
          report_mismatch($sformatf("result %0d checksum %h, expected %h",
                                    results_seen, cs, r.checksum));
        end
        if (tl !== r.too_long) begin
          report_mismatch($sformatf("result %0d too_long %b, expected %b",
                                    results_seen, tl, r.too_long));
        end
      end
      results_seen++;
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         kind = l4pc_pkg::KIND_ADDR;
  logic [l4pc_pkg::WordW-1:0]   value = '0;
  logic [l4pc_pkg::ProtoW-1:0]  protocol = '0;
  logic                         last = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [l4pc_pkg::WordW-1:0]   checksum;
  logic                         too_long;
  logic                         cfg_write = 1'b0;
  logic                         cfg_data = 1'b0;

  checksum_scoreboard checksum_board = new();
  int tx_idle_pct = 12;
  int rx_idle_pct = 78;
  int rx_hold = 0;
  int words_sent = 0;

  l4_pseudo_header_checksum_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .protocol  (protocol),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .checksum  (checksum),
    .too_long  (too_long),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      checksum_board.absorb_word(kind, value, protocol, last);
    end
    if (!rst && out_valid && out_ready) begin
      checksum_board.check_result(checksum, too_long);
    end
  end

  function automatic logic [l4pc_pkg::WordW-1:0] rand_word();
    logic [31:0] r;
    r = $urandom;
    return r[l4pc_pkg::WordW-1:0];
  endfunction

  function automatic logic [l4pc_pkg::ProtoW-1:0] rand_proto();
    logic [31:0] r;
    r = $urandom;
    return r[l4pc_pkg::ProtoW-1:0];
  endfunction

  function automatic logic rand_kind();
    logic [31:0] r;
    r = $urandom;
    return r[0];
  endfunction

  task automatic send_word(logic k, logic [l4pc_pkg::WordW-1:0] v,
                           logic [l4pc_pkg::ProtoW-1:0] p, logic l);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    value <= v;
    protocol <= p;
    last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checksum_board.expected_sums.size() != 0) @(posedge clk);
  endtask

  task automatic write_header_mode(bit m);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_write <= 1'b0;
    checksum_board.set_mode(m);
  endtask

  task automatic send_random_packet();
    int style;
    int n_addr;
    int n_bytes;
    style = $urandom_range(9);
    if (style < 7) begin
      case ($urandom_range(3))
        0: n_addr = 0;
        3: n_addr = 16;
        default: n_addr = 4;
      endcase
      n_bytes = $urandom_range(24);
      if (n_addr == 0 && n_bytes == 0) begin
        n_bytes = 1;
      end
      for (int i = 0; i < n_addr; i++) begin
        send_word(l4pc_pkg::KIND_ADDR, rand_word(), rand_proto(),
                  (n_bytes == 0 && i == n_addr - 1));
      end
      for (int i = 0; i < n_bytes; i++) begin
        send_word(l4pc_pkg::KIND_BYTE, rand_word(), rand_proto(), (i == n_bytes - 1));
      end
    end else begin
      n_bytes = $urandom_range(1, 8);
      for (int i = 0; i < n_bytes; i++) begin
        send_word(rand_kind(), rand_word(), rand_proto(), (i == n_bytes - 1));
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("l4_pseudo_header_checksum_unit verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(l4pc_pkg::KIND_ADDR, 16'hFFFF, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_ADDR, 16'hFFFF, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_ADDR, 16'h0000, 8'hFF, 1'b1);
    send_word(l4pc_pkg::KIND_BYTE, 16'h00FF, 8'hFF, 1'b0);
    send_word(l4pc_pkg::KIND_ADDR, 16'hFFFF, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'h7F00, 8'hAA, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'hAB80, 8'h00, 1'b1);
    send_word(l4pc_pkg::KIND_BYTE, 16'hFFFF, 8'h11, 1'b1);
    send_word(l4pc_pkg::KIND_BYTE, 16'h0045, 8'hFF, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'hFF00, 8'h06, 1'b1);
    send_word(l4pc_pkg::KIND_ADDR, 16'h0000, 8'h00, 1'b1);
    while (words_sent < 290) send_random_packet();

    write_header_mode(1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'h0045, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'h0000, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'h001C, 8'hFF, 1'b0);
    send_word(l4pc_pkg::KIND_ADDR, 16'hC0A8, 8'h00, 1'b0);
    send_word(l4pc_pkg::KIND_BYTE, 16'hFF01, 8'h11, 1'b1);
    send_word(l4pc_pkg::KIND_ADDR, 16'hFFFF, 8'hFF, 1'b1);
    tx_idle_pct = 78;
    rx_idle_pct = 12;
    while (words_sent < 570) send_random_packet();

    write_header_mode(1'b1);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold = 300;
    for (int i = 0; i < 40; i++) begin
      send_word(l4pc_pkg::KIND_BYTE, rand_word(), rand_proto(), 1'b1);
    end
    while (words_sent < 700) send_random_packet();
    wait_results_drained();
    while (words_sent < 780) send_random_packet();

    write_header_mode(1'b0);
    while (words_sent < 850) send_random_packet();
    wait_results_drained();
    repeat (8) @(posedge clk);

    if (checksum_board.expected_sums.size() != 0) begin
      checksum_board.report_mismatch($sformatf("%0d results never arrived",
                                               checksum_board.expected_sums.size()));
    end
    if (checksum_board.errors == 0) begin
      $display("l4_pseudo_header_checksum_unit verification clean");
    end else begin
      $display("l4_pseudo_header_checksum_unit verification failed");
    end
    $finish;
  end

endmodule
